// ===== hw/rtl/pnmh_pkg.sv =====
// ----------------------------------------------------------------------------
// pnmh_pkg
// Types and constants shared by the PNM header parser files.
// ----------------------------------------------------------------------------
package pnmh_pkg;

    // Width that dimensions are held at internally.
    localparam int DIM_BITS = 24;
    // Width of the dimension fields on the result channel.
    localparam int OUT_W    = 24;

    typedef logic [DIM_BITS-1:0] t_dim;
    typedef logic [OUT_W-1:0]    t_out_dim;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_P3   = 3'd3;
    localparam logic [2:0] FMT_P6   = 3'd6;

    localparam logic [1:0] CHAN_ONE   = 2'd1;
    localparam logic [1:0] CHAN_THREE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DIGIT  = 3'd1,
        PH_SPACE  = 3'd2,
        PH_SKIP_W = 3'd3,
        PH_WIDTH  = 3'd4,
        PH_SKIP_H = 3'd5,
        PH_HEIGHT = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_OVF       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EM_NONE  = 2'd0,
        EM_BAD   = 2'd1,
        EM_TRUNC = 2'd2,
        EM_OK    = 2'd3
    } t_emit;

    typedef struct packed {
        t_phase     phase;
        logic       in_comment;
        t_dim       acc;
        t_dim       saved_width;
        logic [2:0] digit;
        logic       overflow;
    } t_state;

    typedef struct packed {
        t_dim val;
        logic ovf;
    } t_acc;

    typedef struct packed {
        t_status    status;
        t_out_dim   image_width;
        t_out_dim   image_height;
        logic [1:0] channel_count;
        logic [2:0] format_digit;
    } t_result;

    localparam t_state RST_STATE = '{
        phase:       PH_IDLE,
        in_comment:  1'b0,
        acc:         '0,
        saved_width: '0,
        digit:       FMT_NONE,
        overflow:    1'b0
    };

endpackage

// ===== hw/rtl/pnmh_in_if.sv =====
// ----------------------------------------------------------------------------
// pnmh_in_if
// Byte channel into the PNM header parser.
// ----------------------------------------------------------------------------
interface pnmh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output final_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input final_byte, output ready);
endinterface

// ===== hw/rtl/pnmh_out_if.sv =====
// ----------------------------------------------------------------------------
// pnmh_out_if
// Result channel out of the PNM header parser.
// ----------------------------------------------------------------------------
interface pnmh_out_if
    import pnmh_pkg::*;
;
    logic       valid;
    logic       ready;
    t_status    status;
    t_out_dim   image_width;
    t_out_dim   image_height;
    logic [1:0] channel_count;
    logic [2:0] format_digit;

    modport source (output valid, output status, output image_width,
                    output image_height, output channel_count,
                    output format_digit, input ready);
    modport sink   (input valid, input status, input image_width,
                    input image_height, input channel_count,
                    input format_digit, output ready);
endinterface

// ===== hw/rtl/pnm_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// pnm_header_parser_unit
// PNM header parser: one file byte per beat in, one result beat per file out.
// ----------------------------------------------------------------------------
// The input beat is captured in the input register; the parse update is then
//   written into the result register.
// Throughput: one byte per cycle while the result register is not held by a stalled sink.
// Reset: synchronous, active low; clears parse state and both valid flags.
module pnm_header_parser_unit
    import pnmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnmh_in_if.sink     i_in,
    pnmh_out_if.source  o_out
);

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_first_byte;
    logic       r_final_byte;

    logic       r_out_valid;
    t_result    r_out;

    logic       adv;
    logic       res_valid;
    t_result    res;

    // result register free or draining this cycle
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;

    pnmh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_valid && adv),
        .i_data_byte  (r_data_byte),
        .i_first_byte (r_first_byte),
        .i_final_byte (r_final_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data_byte  <= i_in.data_byte;
            r_first_byte <= i_in.first_byte;
            r_final_byte <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.image_width   = r_out.image_width;
    assign o_out.image_height  = r_out.image_height;
    assign o_out.channel_count = r_out.channel_count;
    assign o_out.format_digit  = r_out.format_digit;

endmodule

// ===== hw/rtl/pnmh_core.sv =====
// ----------------------------------------------------------------------------
// pnmh_core
// Header parse state and the per-byte update: magic check, whitespace and
// comment skipping, decimal accumulation with saturation, result decode.
// ----------------------------------------------------------------------------
module pnmh_core
    import pnmh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_final_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int   ACC_W   = DIM_BITS + 4;
    localparam t_dim DIM_MAX = '1;

    t_state r_state;
    t_state n_state;
    t_emit  emit;
    t_acc   acc_next;

    logic is_ws;
    logic is_dig;
    logic is_hash;
    logic is_nl;

    // acc * 10 + digit, held at DIM_MAX on overflow
    function automatic t_acc accum(t_dim acc, logic [3:0] dig);
        logic [ACC_W-1:0] v;
        t_acc             r;
        v = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(dig);
        r.ovf = (v > ACC_W'(DIM_MAX));
        r.val = r.ovf ? DIM_MAX : v[DIM_BITS-1:0];
        return r;
    endfunction

    assign is_ws   = (i_data_byte == CH_SPACE) ||
                     (i_data_byte >= CH_HT && i_data_byte <= CH_CR);
    assign is_dig  = (i_data_byte >= CH_0) && (i_data_byte <= CH_9);
    assign is_hash = (i_data_byte == CH_HASH);
    assign is_nl   = (i_data_byte == CH_NL);

    assign acc_next = accum(r_state.acc, i_data_byte[3:0]);

    // next state
    always_comb begin
        n_state = r_state;
        emit    = EM_NONE;
        if (i_first_byte) begin
            n_state = RST_STATE;
            if (i_data_byte != CH_P) begin
                emit = EM_BAD;
            end else if (i_final_byte) begin
                emit = EM_TRUNC;
            end else begin
                n_state.phase = PH_DIGIT;
            end
            if (emit != EM_NONE) begin
                n_state.phase = PH_DONE;
            end
        end else if (r_state.phase != PH_IDLE && r_state.phase != PH_DONE) begin
            if (r_state.in_comment) begin
                if (is_nl) begin
                    n_state.in_comment = 1'b0;
                end
            end else begin
                unique case (r_state.phase)
                    PH_DIGIT: begin
                        if (i_data_byte >= CH_1 && i_data_byte <= CH_6) begin
                            n_state.digit = i_data_byte[2:0];
                            n_state.phase = PH_SPACE;
                        end else begin
                            emit = EM_BAD;
                        end
                    end
                    PH_SPACE: begin
                        if (is_ws) begin
                            n_state.phase = PH_SKIP_W;
                        end else begin
                            emit = EM_BAD;
                        end
                    end
                    PH_SKIP_W: begin
                        priority if (is_hash) begin
                            n_state.in_comment = 1'b1;
                        end else if (is_ws) begin
                            n_state.phase = PH_SKIP_W;
                        end else if (is_dig) begin
                            n_state.phase    = PH_WIDTH;
                            n_state.acc      = acc_next.val;
                            n_state.overflow = r_state.overflow | acc_next.ovf;
                        end else begin
                            // empty width and empty height: byte ends both
                            n_state.saved_width = r_state.acc;
                            n_state.acc         = '0;
                            emit                = EM_OK;
                        end
                    end
                    PH_WIDTH: begin
                        priority if (is_dig) begin
                            n_state.acc      = acc_next.val;
                            n_state.overflow = r_state.overflow | acc_next.ovf;
                        end else if (is_hash) begin
                            n_state.in_comment = 1'b1;
                        end else begin
                            n_state.saved_width = r_state.acc;
                            n_state.acc         = '0;
                            if (is_ws) begin
                                n_state.phase = PH_SKIP_H;
                            end else begin
                                emit = EM_OK;
                            end
                        end
                    end
                    PH_SKIP_H: begin
                        priority if (is_hash) begin
                            n_state.in_comment = 1'b1;
                        end else if (is_ws) begin
                            n_state.phase = PH_SKIP_H;
                        end else if (is_dig) begin
                            n_state.phase    = PH_HEIGHT;
                            n_state.acc      = acc_next.val;
                            n_state.overflow = r_state.overflow | acc_next.ovf;
                        end else begin
                            emit = EM_OK;
                        end
                    end
                    PH_HEIGHT: begin
                        priority if (is_dig) begin
                            n_state.acc      = acc_next.val;
                            n_state.overflow = r_state.overflow | acc_next.ovf;
                        end else if (is_hash) begin
                            n_state.in_comment = 1'b1;
                        end else begin
                            emit = EM_OK;
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
            // end of data: a height in progress counts as complete
            if (emit == EM_NONE && i_final_byte) begin
                emit = (n_state.phase == PH_HEIGHT) ? EM_OK : EM_TRUNC;
            end
            if (emit != EM_NONE) begin
                n_state.phase = PH_DONE;
            end
        end
    end

    // result decode
    always_comb begin
        o_res_valid          = i_en && (emit != EM_NONE);
        o_res.status         = ST_OK;
        o_res.image_width    = '0;
        o_res.image_height   = '0;
        o_res.format_digit   = n_state.digit;
        unique case (emit)
            EM_NONE: begin
                o_res.status = ST_OK;
            end
            EM_BAD: begin
                o_res.status       = ST_BAD_MAGIC;
                o_res.format_digit = FMT_NONE;
            end
            EM_TRUNC: begin
                o_res.status = ST_TRUNC;
            end
            EM_OK: begin
                o_res.status       = n_state.overflow ? ST_OVF : ST_OK;
                o_res.image_width  = OUT_W'(n_state.saved_width);
                o_res.image_height = OUT_W'(n_state.acc);
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
        o_res.channel_count = (o_res.format_digit == FMT_P3 ||
                               o_res.format_digit == FMT_P6) ? CHAN_THREE : CHAN_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RST_STATE;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // every result closes the file
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_state.phase == PH_DONE)
        else $error("result emitted without entering done phase");

    a_bad_no_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == ST_BAD_MAGIC |->
            o_res.format_digit == FMT_NONE && o_res.image_width == '0)
        else $error("bad magic result carries format or size");

    a_trunc_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == ST_TRUNC |->
            o_res.image_width == '0 && o_res.image_height == '0)
        else $error("truncated result carries a size");

    // idle is only left through a first byte
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !i_first_byte && r_state.phase == PH_IDLE |-> !o_res_valid)
        else $error("result from idle without first byte");
`endif

endmodule

// ===== bench/pnm_header_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// pnm_header_parser_unit_test
// Self-checking bench for the PNM header parser: PNM files are fed one byte
// per beat, and each header result beat is compared with a cycle-free model.
// It runs a few hand-built files first, then random files (mostly well-formed
// headers with comments, odd spacing, overflow and cut-off data, plus noise),
// under four source/sink idle patterns.
// ----------------------------------------------------------------------------
module pnm_header_parser_unit_test;
    import pnmh_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam t_dim       DIM_MAX = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       fin;
    } t_byte_beat;

    logic i_clk;
    logic i_rst_n;

    pnmh_in_if  byte_ch ();
    pnmh_out_if hdr_ch ();

    pnm_header_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (hdr_ch)
    );

    t_byte_beat pending_beats[$];
    t_result    expected_headers[$];
    logic [7:0] file_buf[$];
    t_state     hdr;
    int         beats_queued;
    int         beats_taken;
    int         mismatch_count;
    int         src_idle_pct;
    int         snk_stall_pct;

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Header model
    // ------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_HT && b <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic void add_digit(logic [7:0] b);
        logic [DIM_BITS+3:0] v;
        v = (DIM_BITS+4)'(hdr.acc) * (DIM_BITS+4)'(10) + (DIM_BITS+4)'(b - CH_0);
        if (v > DIM_MAX) begin
            hdr.overflow = 1'b1;
            v = DIM_MAX;
        end
        hdr.acc = t_dim'(v);
    endfunction

    function automatic t_result close_header(t_status st);
        t_result    r;
        logic [2:0] d;
        bit         good;
        good = (st == ST_OK || st == ST_OVF);
        d = (st == ST_BAD_MAGIC) ? FMT_NONE : hdr.digit;
        r.status        = st;
        r.image_width   = good ? t_out_dim'(hdr.saved_width) : '0;
        r.image_height  = good ? t_out_dim'(hdr.acc) : '0;
        r.channel_count = (d == FMT_P3 || d == FMT_P6) ? CHAN_THREE : CHAN_ONE;
        r.format_digit  = d;
        hdr.phase = PH_DONE;
        return r;
    endfunction

    function automatic t_status ok_status();
        return hdr.overflow ? ST_OVF : ST_OK;
    endfunction

    // Returns 1 when the beat completes a header; r then holds the result.
    function automatic bit predict_header(input logic [7:0] b, input logic first,
                                          input logic fin, output t_result r);
        bit again;
        r = '0;
        if (first) begin
            hdr = RST_STATE;
            if (b != CH_P) begin
                r = close_header(ST_BAD_MAGIC);
                return 1'b1;
            end
            hdr.phase = PH_DIGIT;
            if (fin) begin
                r = close_header(ST_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end
        if (hdr.phase == PH_IDLE || hdr.phase == PH_DONE)
            return 1'b0;

        if (hdr.in_comment) begin
            if (b == CH_NL)
                hdr.in_comment = 1'b0;
        end else begin
            // the byte that ends a number or a blank run is seen again
            do begin
                again = 1'b0;
                case (hdr.phase)
                    PH_DIGIT: begin
                        if (b < CH_1 || b > CH_6) begin
                            r = close_header(ST_BAD_MAGIC);
                            return 1'b1;
                        end
                        hdr.digit = 3'(b - CH_0);
                        hdr.phase = PH_SPACE;
                    end
                    PH_SPACE: begin
                        if (!is_space(b)) begin
                            r = close_header(ST_BAD_MAGIC);
                            return 1'b1;
                        end
                        hdr.phase = PH_SKIP_W;
                    end
                    PH_SKIP_W, PH_SKIP_H: begin
                        if (b == CH_HASH) begin
                            hdr.in_comment = 1'b1;
                        end else if (!is_space(b)) begin
                            hdr.phase = (hdr.phase == PH_SKIP_W) ? PH_WIDTH : PH_HEIGHT;
                            again = 1'b1;
                        end
                    end
                    PH_WIDTH: begin
                        if (is_digit(b)) begin
                            add_digit(b);
                        end else if (b == CH_HASH) begin
                            hdr.in_comment = 1'b1;
                        end else begin
                            hdr.saved_width = hdr.acc;
                            hdr.acc = '0;
                            hdr.phase = PH_SKIP_H;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        if (is_digit(b)) begin
                            add_digit(b);
                        end else if (b == CH_HASH) begin
                            hdr.in_comment = 1'b1;
                        end else begin
                            r = close_header(ok_status());
                            return 1'b1;
                        end
                    end
                endcase
            end while (again);
        end

        if (fin) begin
            // data ending inside the height still counts as a full header
            r = close_header(hdr.phase == PH_HEIGHT ? ok_status() : ST_TRUNC);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_header(input t_result got);
        t_result want;
        if (expected_headers.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d w=%0d h=%0d",
                                      got.status, got.image_width, got.image_height));
            return;
        end
        want = expected_headers.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
        if (got.image_width !== want.image_width)
            report_mismatch($sformatf("width got %0d want %0d",
                                      got.image_width, want.image_width));
        if (got.image_height !== want.image_height)
            report_mismatch($sformatf("height got %0d want %0d",
                                      got.image_height, want.image_height));
        if (got.channel_count !== want.channel_count)
            report_mismatch($sformatf("channels got %0d want %0d",
                                      got.channel_count, want.channel_count));
        if (got.format_digit !== want.format_digit)
            report_mismatch($sformatf("format got %0d want %0d",
                                      got.format_digit, want.format_digit));
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_space();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_HT;
            2: return CH_NL;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // any byte that is neither digit, blank nor comment start
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_digit(b) || is_space(b) || b == CH_HASH);
        return b;
    endfunction

    task automatic add_comment();
        logic [7:0] b;
        file_buf.push_back(CH_HASH);
        repeat ($urandom_range(4)) begin
            do
                b = 8'($urandom_range(255));
            while (b == CH_NL);
            file_buf.push_back(b);
        end
        file_buf.push_back(CH_NL);
    endtask

    task automatic add_filler();
        repeat ($urandom_range(2)) begin
            if ($urandom_range(1))
                add_comment();
            else
                repeat ($urandom_range(1, 3)) file_buf.push_back(pick_space());
        end
    endtask

    task automatic add_number();
        int    r;
        int    n;
        string s;
        r = $urandom_range(99);
        if (r < 4) begin
            // right at the saturation point
            s = $sformatf("%0d", longint'(DIM_MAX) + $urandom_range(1));
            foreach (s[i]) file_buf.push_back(s[i]);
            return;
        end
        if (r < 9)       n = 0;
        else if (r < 75) n = $urandom_range(1, 4);
        else if (r < 92) n = $urandom_range(5, 7);
        else             n = $urandom_range(8, 10);
        for (int i = 0; i < n; i++) begin
            file_buf.push_back(CH_0 + 8'($urandom_range(9)));
            if (i < n - 1 && $urandom_range(9) == 0)
                add_comment();
        end
    endtask

    task automatic load_text(input string s);
        foreach (s[i]) file_buf.push_back(s[i]);
    endtask

    // Queues file_buf as beats; data stops at fin_at when that is set.
    task automatic push_file(input int fin_at);
        t_byte_beat bt;
        for (int i = 0; i < file_buf.size() && (fin_at < 0 || i <= fin_at); i++) begin
            bt.data  = file_buf[i];
            bt.first = (i == 0);
            bt.fin   = (i == fin_at);
            pending_beats.push_back(bt);
            beats_queued++;
        end
        file_buf.delete();
    endtask

    task automatic queue_random_file();
        int fin_at;
        int hdr_end;
        int r;
        int n;
        fin_at = -1;
        if ($urandom_range(99) < 72) begin
            file_buf.push_back(CH_P);
            file_buf.push_back(CH_0 + 8'($urandom_range(1, 6)));
            file_buf.push_back(pick_space());
            add_filler();
            add_number();
            file_buf.push_back($urandom_range(9) == 0 ? pick_junk() : pick_space());
            add_filler();
            add_number();
            r = $urandom_range(99);
            if (r < 20)
                fin_at = file_buf.size() - 1;
            else if (r < 30)
                file_buf.push_back(pick_junk());
            else
                file_buf.push_back(pick_space());
            hdr_end = file_buf.size();
            // pixel data
            repeat ($urandom_range(4)) file_buf.push_back(8'($urandom_range(255)));
            r = $urandom_range(99);
            if (r < 15)
                fin_at = $urandom_range(hdr_end - 1);
            else if (fin_at < 0 && r < 25)
                fin_at = file_buf.size() - 1;
        end else begin
            n = $urandom_range(1, 10);
            file_buf.push_back($urandom_range(1) ? CH_P : 8'($urandom_range(255)));
            for (int i = 1; i < n; i++)
                file_buf.push_back(8'($urandom_range(255)));
            if (n > 1 && $urandom_range(1))
                file_buf[1] = CH_0 + 8'($urandom_range(9));
            if ($urandom_range(99) < 30)
                fin_at = $urandom_range(n - 1);
        end
        push_file(fin_at);
    endtask

    task automatic wait_drained();
        while (beats_taken != beats_queued || expected_headers.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: predicts on each accepted beat, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        t_result    hdr_res;
        t_byte_beat bt;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                beats_taken++;
                if (predict_header(byte_ch.data_byte, byte_ch.first_byte,
                                   byte_ch.final_byte, hdr_res))
                    expected_headers.push_back(hdr_res);
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    bt = pending_beats.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= bt.data;
                    byte_ch.first_byte <= bt.first;
                    byte_ch.final_byte <= bt.fin;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_headers
        t_result got;
        if (!i_rst_n) begin
            hdr_ch.ready <= 1'b0;
        end else begin
            if (hdr_ch.valid && hdr_ch.ready) begin
                got.status        = hdr_ch.status;
                got.image_width   = hdr_ch.image_width;
                got.image_height  = hdr_ch.image_height;
                got.channel_count = hdr_ch.channel_count;
                got.format_digit  = hdr_ch.format_digit;
                check_header(got);
            end
            hdr_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int queued_mark;
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.first_byte = 1'b0;
        byte_ch.final_byte = 1'b0;
        hdr_ch.ready       = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        beats_queued   = 0;
        beats_taken    = 0;
        mismatch_count = 0;
        hdr = RST_STATE;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain color header, ended by a blank
        load_text("P6\n3 2 ");
        push_file(-1);
        // wrong first byte
        file_buf.push_back(8'hFF);
        push_file(-1);
        // data ends on the first byte
        file_buf.push_back(CH_P);
        push_file(0);
        // digit out of range, then '#' right after the digit
        load_text("P0");
        push_file(-1);
        load_text("P3#");
        push_file(-1);
        // comment splitting the width, data ends inside the height
        load_text("P3 1#\n2 4");
        push_file(8);
        // stray beat after the header is done
        pending_beats.push_back('{data: 8'h00, first: 1'b0, fin: 1'b1});
        beats_queued++;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            queued_mark = beats_queued;
            while (beats_queued - queued_mark < 350)
                queue_random_file();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("pnm_header_parser_unit regression: pass");
        else
            $display("pnm_header_parser_unit regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("pnm_header_parser_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pnmh_pkg.sv
hw/rtl/pnmh_in_if.sv
hw/rtl/pnmh_out_if.sv
hw/rtl/pnmh_core.sv
hw/rtl/pnm_header_parser_unit.sv
bench/pnm_header_parser_unit_test.sv
